FILE: hdl/escape_sequence_decoder_assert.svh
// Assertion helpers for the escape decoder checkers.
// Both macros sample on clk and are held off while arst_n is low.
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define ESD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape decoder check failed");

// Next-cycle implication.
`define ESD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape decoder check failed");

`endif

FILE: hdl/esd_pkg.sv
package esd_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LC_A      = 8'h61;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_UC_A      = 8'h41;
	localparam logic [7:0] CH_UC_F      = 8'h46;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;

	// output queue: room for one item's two results plus two in flight
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} esd_beat_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LC_A && b <= CH_LC_F) ||
			(b >= CH_UC_A && b <= CH_UC_F);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		if (b <= CH_NINE) begin
			v = b - CH_ZERO;
		end else if (b >= CH_LC_A) begin
			v = b - CH_LC_A + 8'd10;
		end else begin
			v = b - CH_UC_A + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic is_oct(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_SEVEN;
	endfunction

endpackage

FILE: hdl/escape_sequence_decoder.sv
// escape_sequence_decoder
//
// Decodes C-style escapes in a byte stream. Input beats arrive on the s_ side
// (one source byte per beat, s_tlast on the final byte of a string); decoded
// bytes leave on the m_ side with m_tlast on the final decoded byte.
//
// Each result is registered into the output queue as its beat is accepted.
// A backslash, x or 0 opener, or a first digit may produce nothing; a
// non-digit ending a numeric escape gives two beats, one if it opens an escape.
// Throughput: one input beat per cycle while outputs are taken at one per
// cycle; the decode is a single pass of small logic into a 4-entry output
// queue, and s_tready is held high while the queue has room for two beats.
// When the receiver stalls, results collect in the queue and s_tready falls
// once fewer than two entries are free; nothing is dropped.
// Reset (arst_n low) empties the queue and returns the decoder to plain text
// mode with no escape in progress.
module escape_sequence_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,  // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast   // out_last
);
	import esd_pkg::*;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2,
		MODE_OCT   = 2'd3
	} mode_t;

	// decoder state
	mode_t      mode_q, mode_d;
	logic       digit_q, digit_d;  // one digit already taken
	logic [7:0] value_q, value_d;

	// output queue
	esd_beat_t        queue_q [QDEPTH];
	logic [QAW-1:0]   head_q, tail_q;
	logic [QCW-1:0]   count_q;

	logic       in_fire, out_fire;
	logic       is_digit;
	logic [7:0] digit_value;
	esd_beat_t  res0, res1;
	logic       res0_v, res1_v;
	logic [1:0] push_n;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// room for a worst-case pair of results
	assign s_tready = count_q <= QCW'(QDEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign m_tdata  = queue_q[head_q].data;
	assign m_tlast  = queue_q[head_q].last;

	// digit check and value accumulation, radix set by the escape kind
	assign is_digit = (mode_q == MODE_HEX) ? is_hex(s_tdata) : is_oct(s_tdata);
	assign digit_value = (mode_q == MODE_HEX) ? {value_q[3:0], hex_val(s_tdata)} :
		{value_q[4:0], s_tdata[2:0]};

	always_comb begin
		res0_v  = 1'b0;
		res1_v  = 1'b0;
		res0    = '{last: s_tlast, data: s_tdata};
		res1    = '{last: s_tlast, data: s_tdata};
		mode_d  = mode_q;
		digit_d = digit_q;
		value_d = value_q;
		case (mode_q)
			MODE_PLAIN: begin
				if (s_tdata == CH_BACKSLASH && !s_tlast) begin
					mode_d = MODE_ESC;
				end else begin
					res0_v = 1'b1;
				end
			end
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				res0_v = 1'b1;
				if (s_tdata == CH_N) begin
					res0.data = CH_LF;
				end else if (s_tdata == CH_R) begin
					res0.data = CH_CR;
				end else if (s_tdata == CH_T) begin
					res0.data = CH_TAB;
				end else if (s_tdata == CH_X || s_tdata == CH_ZERO) begin
					value_d   = '0;
					digit_d   = 1'b0;
					res0.data = '0;
					if (!s_tlast) begin
						res0_v = 1'b0;
						mode_d = (s_tdata == CH_X) ? MODE_HEX : MODE_OCT;
					end
				end
			end
			MODE_HEX, MODE_OCT: begin
				if (is_digit) begin
					value_d = digit_value;
					if (digit_q || s_tlast) begin
						res0_v    = 1'b1;
						res0.data = digit_value;
						mode_d    = MODE_PLAIN;
						digit_d   = 1'b0;
					end else begin
						digit_d = 1'b1;
					end
				end else begin
					// value first, then the byte as plain text unless it opens an escape
					res0_v  = 1'b1;
					res0    = '{last: 1'b0, data: value_q};
					digit_d = 1'b0;
					if (s_tdata == CH_BACKSLASH && !s_tlast) begin
						mode_d = MODE_ESC;
					end else begin
						res1_v = 1'b1;
						mode_d = MODE_PLAIN;
					end
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
			end
		endcase
	end

	assign push_n = in_fire ? ({1'b0, res0_v} + {1'b0, res1_v}) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			digit_q <= 1'b0;
			value_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (in_fire) begin
				mode_q  <= mode_d;
				digit_q <= digit_d;
				value_q <= value_d;
			end
			if (out_fire) begin
				head_q <= head_q + QAW'(1);
			end
			tail_q  <= tail_q + QAW'(push_n);
			count_q <= count_q + QCW'(push_n) - QCW'(out_fire);
		end
	end

	// queue storage, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && res0_v) begin
			queue_q[tail_q] <= res0;
		end
		if (in_fire && res1_v) begin
			queue_q[tail_q + QAW'(1)] <= res1;
		end
	end

endmodule

FILE: hdl/esd_checker.sv
`include "escape_sequence_decoder_assert.svh"

module esd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output beat holds
	`ESD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`ESD_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

	// input only backs off when results are waiting
	`ESD_ASSERT_NOW(a_backpressure, !s_tready, m_tvalid)

	// end of string always yields a result
	`ESD_ASSERT_NEXT(a_last_yields, s_tvalid && s_tready && s_tlast, m_tvalid)

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

FILE: dv/escape_stream_checker.sv
// Watches both stream ports, keeps its own copy of the escape decoder state,
// and checks every output beat against the oldest predicted one.
module escape_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	output int         fail_count,
	output int         pending_beats
);
	import esd_pkg::*;

	typedef enum logic [1:0] {
		DEC_PLAIN,
		DEC_ESCAPE,
		DEC_HEX,
		DEC_OCTAL
	} dec_mode_t;

	dec_mode_t  mode;
	logic       digit_seen;
	logic [7:0] esc_acc;
	esd_beat_t  decoded_q[$];

	// digit value in the current radix, -1 when the byte is not a digit
	function automatic int digit_of(input logic [7:0] b, input logic hex);
		if (b >= CH_ZERO && b <= (hex ? CH_NINE : CH_SEVEN))
			return int'(b) - int'(CH_ZERO);
		if (hex && b >= CH_LC_A && b <= CH_LC_F)
			return int'(b) - int'(CH_LC_A) + 10;
		if (hex && b >= CH_UC_A && b <= CH_UC_F)
			return int'(b) - int'(CH_UC_A) + 10;
		return -1;
	endfunction

	task automatic emit(input logic [7:0] d, input logic l);
		esd_beat_t beat;
		beat.data = d;
		beat.last = l;
		decoded_q = {decoded_q, beat};
	endtask

	task automatic take_plain(input logic [7:0] b, input logic l);
		if (b == CH_BACKSLASH && !l) begin
			mode = DEC_ESCAPE;
		end else begin
			emit(b, l);
			mode = DEC_PLAIN;
		end
	endtask

	task automatic decode_source_byte(input logic [7:0] b, input logic l);
		int digit;
		int radix;
		case (mode)
			DEC_PLAIN: begin
				take_plain(b, l);
			end
			DEC_ESCAPE: begin
				mode = DEC_PLAIN;
				if (b == CH_N) begin
					emit(CH_LF, l);
				end else if (b == CH_R) begin
					emit(CH_CR, l);
				end else if (b == CH_T) begin
					emit(CH_TAB, l);
				end else if (b == CH_X || b == CH_ZERO) begin
					esc_acc = 8'h00;
					digit_seen = 1'b0;
					if (l)
						emit(8'h00, 1'b1);
					else
						mode = (b == CH_X) ? DEC_HEX : DEC_OCTAL;
				end else begin
					emit(b, l);
				end
			end
			default: begin
				digit = digit_of(b, mode == DEC_HEX);
				radix = (mode == DEC_HEX) ? 16 : 8;
				if (digit >= 0) begin
					esc_acc = 8'(int'(esc_acc) * radix + digit);
					if (digit_seen || l) begin
						emit(esc_acc, l);
						mode = DEC_PLAIN;
						digit_seen = 1'b0;
					end else begin
						digit_seen = 1'b1;
					end
				end else begin
					// non-digit closes the escape, then is decoded as text
					emit(esc_acc, 1'b0);
					digit_seen = 1'b0;
					mode = DEC_PLAIN;
					take_plain(b, l);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = DEC_PLAIN;
			digit_seen = 1'b0;
			esc_acc = 8'h00;
			decoded_q.delete();
			fail_count = 0;
			pending_beats <= 0;
		end else begin
			// outputs seen at this edge come from beats accepted earlier
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got data=%02h last=%0b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					if (m_tdata !== decoded_q[0].data) begin
						$display("%0t: data mismatch, expected %02h, got %02h",
							$time, decoded_q[0].data, m_tdata);
						fail_count++;
					end
					if (m_tlast !== decoded_q[0].last) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, decoded_q[0].last, m_tlast);
						fail_count++;
					end
					void'(decoded_q.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				decode_source_byte(s_tdata, s_tlast);
			pending_beats <= decoded_q.size();
		end
	end

endmodule

FILE: dv/escape_sequence_decoder_tb.sv
// Stimulus and verdict for the escape decoder; checking lives in the checker.
module escape_sequence_decoder_tb;
	import esd_pkg::*;

	localparam int SOURCE_BEATS   = 600;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;

	// receiver stall patterns
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HALF,
		RX_HEAVY
	} rx_style_t;

	// building blocks of random source strings
	typedef enum int {
		TOK_NOISE,
		TOK_TEXT,
		TOK_CTRL,
		TOK_LITERAL,
		TOK_HEX,
		TOK_OCT,
		TOK_HEX_CUT,
		TOK_BACKSLASH
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] in_byte
	logic       s_tlast = 1'b0;   // in_last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] out_byte
	logic       m_tlast;          // out_last

	int fail_count;
	int pending_beats;

	int beats_sent = 0;
	int burst_left = 0;
	logic bursty = 1'b1;

	always #6 clk = ~clk;

	escape_sequence_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	escape_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	// Receiver: switches among random stall patterns; two long hold-offs keyed to
	// its own beat count force the output queue full and s_tready low.
	int        rx_beats = 0;
	int        rx_cycle = 0;
	int        hold_left = 0;
	rx_style_t rx_style = RX_FREE;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_beats++;
				if (rx_beats == 120 || rx_beats == 400)
					hold_left = HOLD_CYCLES;
			end
			rx_cycle++;
			if (rx_cycle % 80 == 0)
				rx_style = rx_style_t'($urandom_range(RX_FREE, RX_HEAVY));
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_style)
					RX_FREE:  m_tready <= 1'b1;
					RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
					RX_HALF:  m_tready <= 1'($urandom_range(0, 1));
					default:  m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Offers one source beat and waits for the handshake. Bursts of random
	// length; between bursts tvalid drops for a random gap when bursty.
	task automatic put_beat(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = bursty ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] oct_char();
		return CH_ZERO + 8'($urandom_range(0, 7));
	endfunction

	// One random string of text, noise and escape tokens, some malformed. tlast
	// goes on the final byte and, rarely, mid-string to break a sequence.
	task automatic send_string();
		logic [7:0] text[$];
		token_t     tok;
		int         tokens;
		int         digits;
		tokens = $urandom_range(1, 8);
		bursty = ($urandom_range(0, 3) != 0);
		repeat (tokens) begin
			tok = token_t'($urandom_range(TOK_NOISE, TOK_BACKSLASH));
			case (tok)
				TOK_NOISE: text = {text, 8'($urandom_range(0, 255))};
				TOK_TEXT:  text = {text, 8'($urandom_range(8'h20, 8'h7E))};
				TOK_CTRL: begin
					text = {text, CH_BACKSLASH};
					case ($urandom_range(0, 2))
						0:       text = {text, CH_N};
						1:       text = {text, CH_R};
						default: text = {text, CH_T};
					endcase
				end
				TOK_LITERAL: begin
					text = {text, CH_BACKSLASH};
					text = {text, 8'($urandom_range(0, 255))};
				end
				TOK_HEX: begin
					text = {text, CH_BACKSLASH};
					text = {text, CH_X};
					digits = $urandom_range(0, 3);
					repeat (digits) text = {text, hex_char()};
				end
				TOK_OCT: begin
					text = {text, CH_BACKSLASH};
					text = {text, CH_ZERO};
					digits = $urandom_range(0, 3);
					repeat (digits) text = {text, oct_char()};
					// 8 and 9 are hex digits but end an octal escape
					if ($urandom_range(0, 3) == 0)
						text = {text, CH_NINE - 8'($urandom_range(0, 1))};
				end
				TOK_HEX_CUT: begin
					text = {text, CH_BACKSLASH};
					text = {text, CH_X};
					digits = $urandom_range(0, 1);
					repeat (digits) text = {text, hex_char()};
					text = {text, 8'h67 + 8'($urandom_range(0, 19))};  // g..z
				end
				default: text = {text, CH_BACKSLASH};
			endcase
		end
		foreach (text[i])
			put_beat(text[i], (i == text.size() - 1) || ($urandom_range(0, 40) == 0));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the byte as plain text
		put_beat(8'h00, 1'b0);
		put_beat(8'hFF, 1'b1);
		// control escapes
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_N, 1'b0);
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_R, 1'b0);
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_T, 1'b1);
		// hex escape, second digit closes it at once (0xFA)
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_X, 1'b0);
		put_beat(CH_UC_F, 1'b0);
		put_beat(CH_LC_A, 1'b0);
		// octal escape ended by a non-octal digit: value then the 8 as text
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_ZERO, 1'b0);
		put_beat(CH_SEVEN, 1'b0);
		put_beat(CH_NINE - 8'd1, 1'b0);
		// empty hex escape ended by a backslash that opens a new escape
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_X, 1'b0);
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(8'h71, 1'b0);  // literal q
		// x cut by end of string
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_X, 1'b1);
		// octal digit carrying the end flag
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_ZERO, 1'b0);
		put_beat(CH_ZERO + 8'd5, 1'b1);
		// trailing backslash
		put_beat(CH_BACKSLASH, 1'b1);
		// high byte ends an escape and carries the end flag: two beats
		put_beat(CH_BACKSLASH, 1'b0);
		put_beat(CH_X, 1'b0);
		put_beat(8'hFF, 1'b1);

		while (beats_sent < SOURCE_BEATS)
			send_string();
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending_beats != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_beats == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
